// ===== design/isort_pkg.sv =====
// ----------------------------------------------------------------------------
// isort_pkg: shared types for the insertion sorter
// Data width, the link that runs between neighboring sort cells, and the
// controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package isort_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic  valid;  // cell holds an element
    logic  gt;     // held element is greater than the incoming one
    data_t value;  // held element
  } link_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_e;

endpackage

`default_nettype wire

// ===== design/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter: stable ascending sorter for sets of signed 32-bit values
// A chain of CAPACITY cells keeps the current set in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_axis_tdata_i carries one signed value per transfer,
//   s_axis_tlast_i marks the last value of a set. While a set is collected,
//   one value is taken every cycle; each value lands in its sorted slot in
//   the same cycle it is transferred (all cells compare in parallel).
//   Values arriving while all CAPACITY cells are full are dropped and the
//   set's overflow flag is raised.
//   Output stream: after the transfer with tlast, the chain drains from
//   cell 0 in ascending order, one element per output transfer, starting the
//   next cycle. m_axis_tlast_o marks the greatest element, m_axis_tuser_o
//   carries the overflow flag on every element of the set.
//   The first result is valid in the cycle after the tlast transfer. A set
//   occupies the block until its last stored element (at most CAPACITY)
//   has left; no input is taken while draining (s_axis_tready_o low).
//   Stall: a low m_axis_tready_i simply holds the chain and the current
//   output element.
//   Reset: all cells empty, overflow flag clear, block ready for input.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sorter #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [31:0] value
  input  wire         s_axis_tlast_i,   // last
  // output stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic        m_axis_tlast_o,   // final_res
  output logic        m_axis_tuser_o    // [0] overflow
);

  isort_pkg::state_e state_q, state_d;
  logic              dropped_q, dropped_d;

  isort_pkg::link_t  links [CAPACITY];
  logic              in_xfer, out_xfer, full, ins, shift;
  isort_pkg::data_t  in_value;

  assign in_value = $signed(s_axis_tdata_i);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;
  assign full     = links[CAPACITY-1].valid;
  assign ins      = in_xfer && !full;   // full chain: value is dropped
  assign shift    = out_xfer;

  // Cell chain. Cell 0 sees an always-valid, never-greater neighbor below,
  // so when it updates it takes the new value; the top cell sees an empty cell above.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isort_pkg::link_t prev_l, next_l;
    if (i == 0) begin : g_bot
      assign prev_l = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_mid_lo
      assign prev_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign next_l = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_mid_hi
      assign next_l = links[i+1];
    end
    isort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ins_i   (ins),
      .shift_i (shift),
      .value_i (in_value),
      .prev_i  (prev_l),
      .next_i  (next_l),
      .link_o  (links[i])
    );
  end

  // Next state: fill until tlast, drain until the last element leaves.
  always_comb begin
    state_d   = state_q;
    dropped_d = dropped_q;
    case (state_q)
      isort_pkg::ST_FILL: begin
        if (in_xfer && full) begin
          dropped_d = 1'b1;
        end
        if (in_xfer && s_axis_tlast_i) begin
          state_d = isort_pkg::ST_DRAIN;
        end
      end
      isort_pkg::ST_DRAIN: begin
        if (out_xfer && m_axis_tlast_o) begin
          state_d   = isort_pkg::ST_FILL;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = isort_pkg::ST_FILL;
      end
    endcase
  end

  // Outputs: the bottom cell is the head of the sorted set.
  always_comb begin
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    case (state_q)
      isort_pkg::ST_FILL:  s_axis_tready_o = 1'b1;
      isort_pkg::ST_DRAIN: m_axis_tvalid_o = 1'b1;
      default: begin
        s_axis_tready_o = 1'b0;
        m_axis_tvalid_o = 1'b0;
      end
    endcase
  end

  assign m_axis_tdata_o = links[0].value;
  assign m_axis_tlast_o = !links[1].valid;  // nothing above: greatest element
  assign m_axis_tuser_o = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= isort_pkg::ST_FILL;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dropped_q <= dropped_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/isort_cell.sv =====
// ----------------------------------------------------------------------------
// isort_cell: one slot of the insertion chain
// Holds one element. On insert it keeps its element, takes its lower
// neighbor's element or takes the new value; on drain it takes its upper
// neighbor's element.
// ----------------------------------------------------------------------------
`default_nettype none

module isort_cell (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   ins_i,    // place value_i this cycle
  input  wire                   shift_i,  // move every element one cell down
  input  wire isort_pkg::data_t value_i,  // element being placed (broadcast)
  input  wire isort_pkg::link_t prev_i,   // lower neighbor
  input  wire isort_pkg::link_t next_i,   // upper neighbor
  output isort_pkg::link_t      link_o
);

  logic             valid_q, valid_d;
  isort_pkg::data_t value_q, value_d;
  logic             gt;

  // Strictly greater: equal elements stay below the new one (stable order).
  assign gt = valid_q && (value_q > value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (shift_i) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
    end else if (ins_i) begin
      if (gt || (!valid_q && prev_i.valid)) begin
        valid_d = 1'b1;
        value_d = prev_i.gt ? prev_i.value : value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o = '{valid: valid_q, gt: gt, value: value_q};

endmodule

`default_nettype wire

// ===== verif/insertion_sorter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// insertion_sorter_tb: self-checking bench for the insertion sorter
// Feeds sets of signed values over the input stream and keeps its own sorted
// copy of each set. Every output transfer is matched against the oldest
// predicted element: value, last marker and overflow flag. Directed sets hit
// the value extremes, single-value sets, equal values and a full store with
// dropped values. Random sets follow under several idle/stall mixes, then a
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module insertion_sorter_tb;

  localparam int unsigned CAPACITY   = 16;
  localparam int          CLK_HALF   = 6;          // 12 ns period
  localparam int          RST_CYCLES = 12;
  localparam int          TIMEOUT_NS = 3_000_000;  // far beyond a slow correct run
  localparam int          MAX_REPORT = 10;
  localparam int          DRAIN_WAIT = 2 * CAPACITY + 8;

  localparam isort_pkg::data_t VAL_MIN = 32'sh8000_0000;
  localparam isort_pkg::data_t VAL_MAX = 32'sh7fff_ffff;

  // One predicted output transfer.
  typedef struct packed {
    isort_pkg::data_t value;
    logic             last;
    logic             ovf;
  } sorted_item_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             s_tvalid = 1'b0;
  isort_pkg::data_t s_tdata  = '0;
  logic             s_tlast  = 1'b0;
  logic             m_tready = 1'b0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;

  insertion_sorter #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),          // [31:0] value
    .s_axis_tlast_i (s_tlast),          // last
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),   // [31:0] sorted_value
    .m_axis_tlast_o (m_axis_tlast_o),   // final_res
    .m_axis_tuser_o (m_axis_tuser_o)    // [0] overflow
  );

  always #CLK_HALF clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  int send_idle_pct = 0;   // chance per cycle that the sender sits idle
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
  int hold_left = 0;       // forced receiver hold-off, counted down below
  int errors = 0;
  int items_sent = 0;

  // Shadow of the block: current set kept in ascending order, plus the
  // overflow flag for that set.
  isort_pkg::data_t set_shadow[$];
  logic             set_dropped = 1'b0;
  sorted_item_t     pending_results[$];

  // --------------------------------------------------------------------------
  // Predictor: stable insertion, after every equal entry. A full store drops
  // the value, the one carrying last too. The last transfer releases the set.
  // --------------------------------------------------------------------------
  function automatic void sort_insert(input isort_pkg::data_t v, input logic l);
    int           pos;
    int           n;
    sorted_item_t item;
    if (set_shadow.size() >= CAPACITY) begin
      set_dropped = 1'b1;
    end else begin
      pos = set_shadow.size();
      while (pos > 0 && set_shadow[pos-1] > v) pos--;
      set_shadow.insert(pos, v);
    end
    if (l) begin
      n = set_shadow.size();
      for (int k = 0; k < n; k++) begin
        item.value = set_shadow[k];
        item.last  = (k == n - 1);
        item.ovf   = set_dropped;
        pending_results.push_back(item);
      end
      set_shadow.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: input transfers feed the predictor first, then output transfers
  // are checked, all from pre-edge values sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    sorted_item_t exp_item;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) sort_insert(s_tdata, s_tlast);
      if (m_axis_tvalid_o && m_tready) begin
        if (pending_results.size() == 0) begin
          if (errors < MAX_REPORT)
            $display("%0t: unexpected output: value %0d last %b ovf %b", $realtime,
                     $signed(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o);
          errors++;
        end else begin
          exp_item = pending_results.pop_front();
          if (m_axis_tdata_o !== exp_item.value || m_axis_tlast_o !== exp_item.last ||
              m_axis_tuser_o !== exp_item.ovf) begin
            if (errors < MAX_REPORT)
              $display("%0t: mismatch: exp value %0d last %b ovf %b, got %0d %b %b",
                       $realtime, exp_item.value, exp_item.last, exp_item.ovf,
                       $signed(m_axis_tdata_o), m_axis_tlast_o, m_axis_tuser_o);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a forced hold-off while hold_left runs down.
  // Sole driver of m_tready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold the transfer until it is taken.
  // Always entered and left at a rising edge, so tvalid sees one assignment
  // per step.
  // --------------------------------------------------------------------------
  task automatic send_value(input isort_pkg::data_t v, input logic l);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
  endtask

  // Sender goes quiet until every predicted element has come out. The first
  // edge lets the monitor book the final input transfer before the check.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Mix of extremes, a small range that makes duplicates, and full range.
  function automatic isort_pkg::data_t pick_value();
    case ($urandom_range(9))
      0:       pick_value = VAL_MIN;
      1:       pick_value = VAL_MAX;
      2, 3:    pick_value = $signed($urandom_range(15)) - 8;
      4:       pick_value = VAL_MIN + $urandom_range(3);
      5:       pick_value = VAL_MAX - $urandom_range(3);
      default: pick_value = $urandom;
    endcase
  endfunction

  // Mostly short sets, some that fill the store or spill past it.
  function automatic int pick_set_len();
    int r;
    r = $urandom_range(99);
    if (r < 60)      pick_set_len = $urandom_range(6, 1);
    else if (r < 85) pick_set_len = $urandom_range(15, 7);
    else             pick_set_len = $urandom_range(CAPACITY + 4, CAPACITY);
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_value(pick_value(), i == len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Single-value sets, extremes in one set, equal values, and a full store
  // where the value carrying last is itself dropped.
  task automatic test_directed();
    send_value(VAL_MIN, 1'b1);
    send_value(VAL_MAX, 1'b1);
    send_value(32'sd0, 1'b1);
    send_value(VAL_MAX, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(32'sd1, 1'b1);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b0);
    send_value(32'sd5, 1'b1);
    for (int i = 0; i <= CAPACITY; i++)
      send_value(isort_pkg::data_t'(CAPACITY - i) * 32'sh0800_0001, i == CAPACITY);
    wait_drained();
  endtask

  // Random sets under one idle/stall mix; ends with the sender paused until
  // the block has emptied.
  task automatic test_random(input int s_pct, input int r_pct, input int quota);
    int start;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    start = items_sent;
    while (items_sent - start < quota) send_set(pick_set_len());
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while an overflowing set drains;
  // the sender keeps offering the next set and gets stalled.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = 150;
    send_set(CAPACITY + 4);
    send_set(6);
    send_set(CAPACITY);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(0, 0, 100);
    test_random(47, 0, 100);
    test_random(0, 47, 100);
    test_random(10, 10, 100);
    test_backpressure();

    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[insertion_sorter] OK");
    end else begin
      $display("[insertion_sorter] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("timeout: %0d elements still expected", pending_results.size());
    $display("[insertion_sorter] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/isort_pkg.sv
design/isort_cell.sv
design/insertion_sorter.sv
verif/insertion_sorter_tb.sv
